// ===== rtl/bitmap_find_set_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Bitmap find-set engine: assertion macros
// Shared concurrent checks, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIND_SET_ENGINE_ASSERT_SVH
`define BITMAP_FIND_SET_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define BMFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmfs: same-cycle check failed");

// Next-cycle implication.
`define BMFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmfs: next-cycle check failed");

`endif

// ===== rtl/bmfs_pkg.sv =====
// ----------------------------------------------------------------------------
// bmfs_pkg
// Types, codes and helper functions of the bitmap find-set engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bmfs_pkg;

    localparam int MAX_BITS_DEF = 1024;
    localparam int IDX_W        = 10;
    localparam int SIZE_W       = 11;
    localparam int CMD_W        = 3;
    localparam int ADDR_SPACE   = 1 << IDX_W;
    localparam int WORD_W       = 32;
    localparam int BIT_SEL_W    = $clog2(WORD_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_SET       = 3'd0,
        CMD_CLEAR     = 3'd1,
        CMD_READ      = 3'd2,
        CMD_FIND      = 3'd3,
        CMD_FIND_CLR  = 3'd4,
        CMD_NEXT_UP   = 3'd5,
        CMD_NEXT_DOWN = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WB,
        ST_RD_RD,
        ST_RD_OUT,
        ST_SETUP,
        ST_SCAN,
        ST_HIT
    } state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_BIT,
        RES_HIT
    } res_sel_t;

    typedef struct packed {
        logic     cmd_load;
        logic     mem_rd_idx;
        logic     wb_bit;
        logic     wb_clear;
        logic     scan_init;
        logic     scan_step;
        logic     res_load;
        res_sel_t res_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic wr_ok;
        logic scan_none;
        logic hit;
        logic scan_end;
        logic clear_on_hit;
    } dp_status_t;

    // Bits strictly above k.
    function automatic logic [WORD_W-1:0] gt_mask(input logic [BIT_SEL_W-1:0] k);
        logic [WORD_W-1:0] ones;
        ones = '1;
        return (ones << 1) << k;
    endfunction

    // Bits strictly below k.
    function automatic logic [WORD_W-1:0] lt_mask(input logic [BIT_SEL_W-1:0] k);
        logic [WORD_W-1:0] ones;
        ones = '1;
        return ~(ones << k);
    endfunction

    // Bits at or below k.
    function automatic logic [WORD_W-1:0] le_mask(input logic [BIT_SEL_W-1:0] k);
        return ~gt_mask(k);
    endfunction

    function automatic logic [BIT_SEL_W-1:0] lsb_index(input logic [WORD_W-1:0] w);
        logic [BIT_SEL_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) idx = BIT_SEL_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [BIT_SEL_W-1:0] msb_index(input logic [WORD_W-1:0] w);
        logic [BIT_SEL_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (w[i]) idx = BIT_SEL_W'(i);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bmfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmfs_ctrl
// Command sequencer: steps each request through read, write-back or scan.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_find_set_engine_assert.svh"

module bmfs_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [bmfs_pkg::CMD_W-1:0] cmd,
    input  wire bmfs_pkg::dp_status_t      st,
    output logic                           busy,
    output bmfs_pkg::ctrl_cmd_t            ctrl
);
    import bmfs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        ctrl         = '0;
        ctrl.res_sel = RES_ZERO;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    ctrl.cmd_load = 1'b1;
                    unique case (cmd)
                        CMD_SET, CMD_CLEAR: state_next = ST_WR_RD;
                        CMD_READ:           state_next = ST_RD_RD;
                        CMD_FIND, CMD_FIND_CLR, CMD_NEXT_UP, CMD_NEXT_DOWN:
                                            state_next = ST_SETUP;
                        default:            ctrl.res_load = 1'b1;
                    endcase
                end
            end
            ST_WR_RD:
            begin
                if (st.wr_ok) begin
                    ctrl.mem_rd_idx = 1'b1;
                    state_next      = ST_WR_WB;
                end
                else begin
                    ctrl.res_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_WR_WB:
            begin
                ctrl.wb_bit   = 1'b1;
                ctrl.res_load = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_RD_RD:
            begin
                ctrl.mem_rd_idx = 1'b1;
                state_next      = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                ctrl.res_load = 1'b1;
                ctrl.res_sel  = RES_BIT;
                state_next    = ST_IDLE;
            end
            ST_SETUP:
            begin
                if (st.scan_none) begin
                    ctrl.res_load = 1'b1;
                    state_next    = ST_IDLE;
                end
                else begin
                    ctrl.scan_init = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (st.hit) begin
                    state_next = ST_HIT;
                end
                else if (st.scan_end) begin
                    ctrl.res_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_HIT:
            begin
                ctrl.wb_clear = st.clear_on_hit;
                ctrl.res_load = 1'b1;
                ctrl.res_sel  = RES_HIT;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `BMFS_ASSERT_NXT(a_res_then_idle, clk, rst_n, ctrl.res_load, state_reg == ST_IDLE)
    `BMFS_ASSERT_IMP(a_wb_after_read, clk, rst_n, ctrl.wb_bit, $past(ctrl.mem_rd_idx))
    `BMFS_ASSERT_NXT(a_hit_one_cycle, clk, rst_n, state_reg == ST_HIT, state_reg == ST_IDLE)

endmodule

`default_nettype wire

// ===== rtl/bmfs_dp.sv =====
// ----------------------------------------------------------------------------
// bmfs_dp
// Flag word store, size register, word-serial scan pipe and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_find_set_engine_assert.svh"

module bmfs_dp #(
    parameter int MAX_BITS = bmfs_pkg::MAX_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [bmfs_pkg::CMD_W-1:0]  cmd,
    input  wire logic [bmfs_pkg::IDX_W-1:0]  flag_index,
    input  wire logic                        range_check,
    input  wire logic                        cfg_wr_en,
    input  wire logic [bmfs_pkg::SIZE_W-1:0] cfg_wr_data,
    input  wire bmfs_pkg::ctrl_cmd_t         ctrl,
    output bmfs_pkg::dp_status_t             st,
    output logic                             done,
    output logic                             bit_value,
    output logic                             found,
    output logic [bmfs_pkg::IDX_W-1:0]       position
);
    import bmfs_pkg::*;

    localparam int LIVE_BITS = (MAX_BITS < ADDR_SPACE) ? MAX_BITS : ADDR_SPACE;
    localparam int NUM_WORDS = (LIVE_BITS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int VCNT_W    = $clog2(NUM_WORDS + 2);
    localparam logic [SIZE_W-1:0] LIVE_SIZE = SIZE_W'(LIVE_BITS);

    // Configuration and latched request
    logic [SIZE_W-1:0]    size_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 chk_reg;

    // Word store
    logic [WORD_W-1:0]    mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] wvalid_reg;
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 rd_valid_reg;

    // Scan pipe: issue stage and evaluate stage
    logic [WADDR_W-1:0]   iss_ptr_reg;
    logic [WADDR_W-1:0]   iss_ptr_next;
    logic [VCNT_W-1:0]    iss_left_reg;
    logic                 iss_first_reg;
    logic                 ev_valid_reg;
    logic [WADDR_W-1:0]   ev_ptr_reg;
    logic                 ev_first_reg;
    logic                 ev_last_reg;

    // Captured hit
    logic [WADDR_W-1:0]   hit_ptr_reg;
    logic [BIT_SEL_W-1:0] hit_bit_reg;
    logic [WORD_W-1:0]    hit_word_reg;

    // Result registers
    logic                 done_reg;
    logic                 bit_value_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     position_reg;

    logic                 idx_ok;
    logic                 idx_live;
    logic                 is_next;
    logic                 dir_down;
    logic [SIZE_W-1:0]    size_m1;
    logic [WADDR_W-1:0]   lastw;
    logic [BIT_SEL_W-1:0] tail_bit;
    logic [WADDR_W-1:0]   idx_word;
    logic [BIT_SEL_W-1:0] idx_bit;
    logic [WORD_W-1:0]    rd_word;
    logic [WORD_W-1:0]    live_mask;
    logic [WORD_W-1:0]    range_mask;
    logic [WORD_W-1:0]    cand;
    logic                 hit;
    logic [BIT_SEL_W-1:0] hit_bit;
    logic [WORD_W-1:0]    wr_word_mod;
    logic                 mem_we;
    logic                 mem_re;
    logic [WADDR_W-1:0]   mem_waddr;
    logic [WADDR_W-1:0]   mem_raddr;
    logic [WORD_W-1:0]    mem_wdata;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            size_reg <= LIVE_SIZE;
        end
        else if (cfg_wr_en) begin
            size_reg <= (cfg_wr_data > LIVE_SIZE) ? LIVE_SIZE : cfg_wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.cmd_load) begin
            cmd_reg <= cmd;
            idx_reg <= flag_index;
            chk_reg <= range_check;
        end
    end

    assign idx_ok   = ({1'b0, idx_reg} < LIVE_SIZE);
    assign idx_live = ({1'b0, idx_reg} < size_reg);
    assign is_next  = (cmd_reg == CMD_NEXT_UP) || (cmd_reg == CMD_NEXT_DOWN);
    assign dir_down = (cmd_reg == CMD_NEXT_DOWN);
    assign size_m1  = size_reg - SIZE_W'(1);
    assign lastw    = WADDR_W'(size_m1 >> BIT_SEL_W);
    assign tail_bit = size_m1[BIT_SEL_W-1:0];
    assign idx_word = WADDR_W'(idx_reg >> BIT_SEL_W);
    assign idx_bit  = idx_reg[BIT_SEL_W-1:0];
    assign rd_word  = rd_valid_reg ? rd_data_reg : '0;

    assign st.wr_ok        = idx_ok && !(chk_reg && !idx_live);
    assign st.scan_none    = (size_reg == '0) || (is_next && !idx_live);
    assign st.clear_on_hit = (cmd_reg == CMD_FIND_CLR);

    // Evaluate the word returned for the previous issue
    always_comb
    begin
        live_mask = (ev_ptr_reg == lastw) ? le_mask(tail_bit) : '1;
        if (!is_next) begin
            range_mask = '1;
        end
        else if (ev_first_reg) begin
            range_mask = dir_down ? lt_mask(idx_bit) : gt_mask(idx_bit);
        end
        else if (ev_last_reg) begin
            range_mask = dir_down ? gt_mask(idx_bit) : lt_mask(idx_bit);
        end
        else begin
            range_mask = '1;
        end
    end

    assign cand        = rd_word & live_mask & range_mask;
    assign hit         = ev_valid_reg && (cand != '0);
    assign hit_bit     = dir_down ? msb_index(cand) : lsb_index(cand);
    assign st.hit      = hit;
    assign st.scan_end = ev_valid_reg && ev_last_reg && (cand == '0);

    always_comb
    begin
        if (dir_down) begin
            iss_ptr_next = (iss_ptr_reg == '0) ? lastw : iss_ptr_reg - WADDR_W'(1);
        end
        else begin
            iss_ptr_next = (iss_ptr_reg == lastw) ? '0 : iss_ptr_reg + WADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            iss_ptr_reg   <= '0;
            iss_left_reg  <= '0;
            iss_first_reg <= 1'b0;
            ev_valid_reg  <= 1'b0;
            ev_ptr_reg    <= '0;
            ev_first_reg  <= 1'b0;
            ev_last_reg   <= 1'b0;
        end
        else if (ctrl.scan_init) begin
            iss_ptr_reg   <= is_next ? idx_word : '0;
            iss_left_reg  <= VCNT_W'(lastw) + (is_next ? VCNT_W'(2) : VCNT_W'(1));
            iss_first_reg <= 1'b1;
            ev_valid_reg  <= 1'b0;
        end
        else if (ctrl.scan_step) begin
            ev_valid_reg <= (iss_left_reg != '0);
            ev_ptr_reg   <= iss_ptr_reg;
            ev_first_reg <= iss_first_reg;
            ev_last_reg  <= (iss_left_reg == VCNT_W'(1));
            if (iss_left_reg != '0) begin
                iss_ptr_reg   <= iss_ptr_next;
                iss_left_reg  <= iss_left_reg - VCNT_W'(1);
                iss_first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.scan_step && hit) begin
            hit_ptr_reg  <= ev_ptr_reg;
            hit_bit_reg  <= hit_bit;
            hit_word_reg <= rd_word & ~(WORD_W'(1) << hit_bit);
        end
    end

    // Store access
    always_comb
    begin
        wr_word_mod          = rd_word;
        wr_word_mod[idx_bit] = (cmd_reg == CMD_SET);
    end

    assign mem_we    = ctrl.wb_bit || ctrl.wb_clear;
    assign mem_waddr = ctrl.wb_clear ? hit_ptr_reg : idx_word;
    assign mem_wdata = ctrl.wb_clear ? hit_word_reg : wr_word_mod;
    assign mem_re    = (ctrl.mem_rd_idx && idx_ok) || (ctrl.scan_step && (iss_left_reg != '0));
    assign mem_raddr = ctrl.scan_step ? iss_ptr_reg : idx_word;

    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Words never written read as zero
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wvalid_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end
        else begin
            if (mem_we) begin
                wvalid_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re) begin
                rd_valid_reg <= wvalid_reg[mem_raddr];
            end
        end
    end

    // Result
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= ctrl.res_load;
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.res_load) begin
            unique case (ctrl.res_sel)
                RES_BIT:
                begin
                    bit_value_reg <= idx_ok && rd_word[idx_bit];
                    found_reg     <= 1'b0;
                    position_reg  <= '0;
                end
                RES_HIT:
                begin
                    bit_value_reg <= 1'b0;
                    found_reg     <= 1'b1;
                    position_reg  <= (IDX_W'(hit_ptr_reg) << BIT_SEL_W) | IDX_W'(hit_bit_reg);
                end
                default:
                begin
                    bit_value_reg <= 1'b0;
                    found_reg     <= 1'b0;
                    position_reg  <= '0;
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign bit_value = bit_value_reg;
    assign found     = found_reg;
    assign position  = position_reg;

    `BMFS_ASSERT_IMP(a_found_live, clk, rst_n, done_reg && found_reg, SIZE_W'(position_reg) < size_reg)
    `BMFS_ASSERT_IMP(a_no_rw_clash, clk, rst_n, mem_we, !mem_re)
    `BMFS_ASSERT_IMP(a_clear_after_hit, clk, rst_n, ctrl.wb_clear, $past(ctrl.scan_step && hit))

endmodule

`default_nettype wire

// ===== rtl/bitmap_find_set_engine.sv =====
// ----------------------------------------------------------------------------
// bitmap_find_set_engine
// Packed flag bitmap with set, clear, read, find-first and wrapping search.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  --------------------------------------
//  request   start && !busy         cmd, flag_index, range_check
//  result    done (one cycle)       bit_value, found, position
//  config    cfg_wr_en              cfg_wr_data (bits_in_use)
//
// Steps per request: set and clear read the word and then write it back,
// read reads the word and then loads the result, a write that the range
// check drops and the unused code load the result at once, and find and
// next searches set up, then scan the 32-bit words (live words, plus one
// more for a next search since the start word is seen twice) until a hit
// or the end. The single read port of the word store, one word a cycle,
// sets the scan length. The result strobe is registered from the result
// load and is never held off. Reset clears the bitmap at once through
// per-word valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_find_set_engine #(
    parameter int MAX_BITS = bmfs_pkg::MAX_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [bmfs_pkg::CMD_W-1:0]  cmd,
    input  wire logic [bmfs_pkg::IDX_W-1:0]  flag_index,
    input  wire logic                        range_check,
    output logic                             done,
    output logic                             bit_value,
    output logic                             found,
    output logic [bmfs_pkg::IDX_W-1:0]       position,
    input  wire logic                        cfg_wr_en,
    input  wire logic [bmfs_pkg::SIZE_W-1:0] cfg_wr_data
);
    import bmfs_pkg::*;

    // Commands from the sequencer, status back from the datapath
    ctrl_cmd_t  ctrl;
    dp_status_t st;

    // Sequencer: walks each request through its read, write-back or scan steps
    bmfs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .st    (st),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    // Datapath: word store with valid bits, size register, scan pipe, result
    bmfs_dp #(
        .MAX_BITS (MAX_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .flag_index  (flag_index),
        .range_check (range_check),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctrl        (ctrl),
        .st          (st),
        .done        (done),
        .bit_value   (bit_value),
        .found       (found),
        .position    (position)
    );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap find-set engine. A behavioral image of
// the flag bitmap predicts every result. Requests run through directed
// corner cases, then random traffic over several live sizes. Every strobed
// result is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bmfs_pkg::*;

    // The one code that the package enum leaves out: the block answers it
    // with an all-zero result and touches nothing.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    localparam int     FLAG_COUNT    = MAX_BITS_DEF;
    localparam int     IDLE_PCT      = 34;
    localparam int     DRAIN_LIMIT   = 1000;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     END_SETTLE    = 50;
    localparam longint RUN_LIMIT_NS  = 20_000_000;

    typedef struct packed {
        logic             bit_value;
        logic             found;
        logic [IDX_W-1:0] position;
    } flag_result_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  flag_index;
    logic              range_check;
    logic              done;
    logic              bit_value;
    logic              found;
    logic [IDX_W-1:0]  position;
    logic              cfg_wr_en;
    logic [SIZE_W-1:0] cfg_wr_data;

    // Bench-side image of the flag store and of the live size.
    bit [FLAG_COUNT-1:0] flag_image;
    int                  live_span;

    // Predicted results, oldest first.
    flag_result_t        pending_results[$];

    int                  error_count;
    bit                  idle_enabled;

    bitmap_find_set_engine #(
        .MAX_BITS (FLAG_COUNT)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .flag_index  (flag_index),
        .range_check (range_check),
        .done        (done),
        .bit_value   (bit_value),
        .found       (found),
        .position    (position),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 20 ns clock, low first.
    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Compute the result of one request and advance the flag image.
    function automatic flag_result_t predict_flag_result(
        input logic [CMD_W-1:0] op,
        input logic [IDX_W-1:0] idx,
        input logic             chk
    );
        flag_result_t r;
        int           pos;
        r = '0;
        case (op)
            CMD_SET, CMD_CLEAR:
            begin
                // Drop a range-checked write at or past the live size; an
                // unchecked one lands even outside the live window.
                if (!(chk && int'(idx) >= live_span))
                    flag_image[idx] = (op == CMD_SET);
            end
            CMD_READ:
            begin
                r.bit_value = flag_image[idx];
            end
            CMD_FIND, CMD_FIND_CLR:
            begin
                for (int i = 0; i < live_span; i++)
                begin
                    if (flag_image[i])
                    begin
                        if (op == CMD_FIND_CLR)
                            flag_image[i] = 1'b0;
                        r.found    = 1'b1;
                        r.position = IDX_W'(i);
                        break;
                    end
                end
            end
            CMD_NEXT_UP, CMD_NEXT_DOWN:
            begin
                // Walk away from the start with wrap; the start flag itself
                // is never a hit.
                if (int'(idx) < live_span)
                begin
                    pos = int'(idx);
                    for (int t = 1; t < live_span; t++)
                    begin
                        if (op == CMD_NEXT_UP)
                            pos = (pos + 1 >= live_span) ? 0 : pos + 1;
                        else
                            pos = (pos == 0) ? live_span - 1 : pos - 1;
                        if (flag_image[pos])
                        begin
                            r.found    = 1'b1;
                            r.position = IDX_W'(pos);
                            break;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Issue one request. Enter and leave on a falling edge; start stays high
    // on return so the next request can follow with no gap.
    task automatic send_request(
        input logic [CMD_W-1:0] op,
        input logic [IDX_W-1:0] idx,
        input logic             chk
    );
        int gap;
        gap = 0;
        if (idle_enabled)
        begin
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd         <= op;
        flag_index  <= idx;
        range_check <= chk;
        start       <= 1'b1;
        // Hold the request until the block takes it.
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_flag_result(op, idx, chk));
        @(negedge clk);
    endtask

    // Drop start and wait until every predicted result has come back.
    task automatic wait_for_results(input int settle);
        int waited;
        start  <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
            error_count++;
        end
        repeat (settle) @(negedge clk);
    endtask

    // Change the live size; only legal with the block idle.
    task automatic write_size(input logic [SIZE_W-1:0] value);
        wait_for_results(SETTLE_CYCLES);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        live_span   = (int'(value) > FLAG_COUNT) ? FLAG_COUNT : int'(value);
    endtask

    // Random traffic. Bias indices into the live window so the bitmap fills
    // and the scans have something to find, with some hits on the size
    // boundary and some over the whole index range.
    task automatic run_random(input int count);
        logic [CMD_W-1:0] op;
        logic [IDX_W-1:0] idx;
        int               roll;
        int               edge_pos;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < 28)
                op = CMD_SET;
            else if (roll < 42)
                op = CMD_CLEAR;
            else if (roll < 56)
                op = CMD_READ;
            else if (roll < 68)
                op = CMD_FIND;
            else if (roll < 78)
                op = CMD_FIND_CLR;
            else if (roll < 88)
                op = CMD_NEXT_UP;
            else if (roll < 98)
                op = CMD_NEXT_DOWN;
            else
                op = CMD_UNUSED;

            roll = $urandom_range(99);
            if (roll < 70 && live_span > 0)
                idx = IDX_W'($urandom_range(live_span - 1));
            else if (roll < 85)
            begin
                edge_pos = live_span - 1 + int'($urandom_range(2));
                if (edge_pos < 0)
                    edge_pos = 0;
                if (edge_pos > FLAG_COUNT - 1)
                    edge_pos = FLAG_COUNT - 1;
                idx = IDX_W'(edge_pos);
            end
            else
                idx = IDX_W'($urandom);

            send_request(op, idx, 1'($urandom));
        end
    endtask

    // Result checker: every strobe pops the oldest prediction.
    always @(posedge clk)
    begin
        flag_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result bit_value=%0b found=%0b position=%0d",
                         $time, bit_value, found, position);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (bit_value !== want.bit_value)
                begin
                    $display("%0t: bit_value mismatch: expected %0b, actual %0b",
                             $time, want.bit_value, bit_value);
                    error_count++;
                end
                if (found !== want.found)
                begin
                    $display("%0t: found mismatch: expected %0b, actual %0b",
                             $time, want.found, found);
                    error_count++;
                end
                if (position !== want.position)
                begin
                    $display("%0t: position mismatch: expected %0d, actual %0d",
                             $time, want.position, position);
                    error_count++;
                end
            end
        end
    end

    // Right after reset: nothing is set anywhere, and the unused code
    // answers with zeros.
    task automatic test_empty_bitmap();
        send_request(CMD_READ, 10'd1023, 1'b0);
        send_request(CMD_FIND_CLR, 10'd0, 1'b0);
        send_request(CMD_NEXT_DOWN, 10'd0, 1'b1);
        send_request(CMD_UNUSED, 10'd1023, 1'b1);
    endtask

    // Both ends of the full map: first-set order, consume on find, wrap in
    // both directions, and a search whose only set flag is its own start.
    task automatic test_extremes();
        send_request(CMD_SET, 10'd0, 1'b0);
        send_request(CMD_SET, 10'd1023, 1'b1);
        send_request(CMD_READ, 10'd1023, 1'b0);
        send_request(CMD_FIND, 10'd512, 1'b0);
        send_request(CMD_FIND_CLR, 10'd0, 1'b1);
        send_request(CMD_FIND, 10'd0, 1'b0);
        send_request(CMD_NEXT_UP, 10'd1023, 1'b0);
        send_request(CMD_SET, 10'd5, 1'b0);
        send_request(CMD_NEXT_UP, 10'd1023, 1'b0);
        send_request(CMD_NEXT_DOWN, 10'd5, 1'b0);
        send_request(CMD_CLEAR, 10'd1023, 1'b1);
    endtask

    // Live size corners: range check at the boundary, a stored flag outside
    // the window, a search from outside it, size one, size zero and a size
    // past the top that saturates.
    task automatic test_size_edges();
        write_size(11'd8);
        send_request(CMD_SET, 10'd8, 1'b1);
        send_request(CMD_SET, 10'd8, 1'b0);
        send_request(CMD_READ, 10'd8, 1'b1);
        send_request(CMD_FIND, 10'd0, 1'b0);
        send_request(CMD_NEXT_DOWN, 10'd9, 1'b0);
        write_size(11'd1);
        send_request(CMD_SET, 10'd0, 1'b1);
        send_request(CMD_NEXT_UP, 10'd0, 1'b0);
        write_size(11'd0);
        send_request(CMD_SET, 10'd3, 1'b1);
        send_request(CMD_FIND, 10'd3, 1'b0);
        write_size(11'd2047);
        send_request(CMD_FIND_CLR, 10'd0, 1'b0);
        send_request(CMD_FIND_CLR, 10'd0, 1'b0);
    endtask

    // Long random run over the full map, where scans are longest.
    task automatic test_random_full();
        write_size(11'd1024);
        run_random(700);
    endtask

    // Random runs over a spread of sizes, mostly small, with the word
    // boundaries and the out-of-range register values among them.
    task automatic test_random_sizes();
        logic [SIZE_W-1:0] sizes [10];
        sizes = '{11'd1, 11'd2, 11'd31, 11'd32, 11'd33, 11'd0, 11'd200,
                  11'd1025, 11'd2047, 11'd513};
        foreach (sizes[k])
        begin
            write_size(sizes[k]);
            run_random(96);
        end
    endtask

    // Requests back to back with no sender gaps.
    task automatic test_back_to_back();
        write_size(11'd64);
        idle_enabled = 1'b0;
        run_random(250);
        idle_enabled = 1'b1;
    endtask

    // Hold off mid-stream until the block has answered everything.
    task automatic test_drain_pause();
        write_size(11'd100);
        run_random(20);
        wait_for_results(0);
        run_random(20);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = CMD_SET;
        flag_index   = '0;
        range_check  = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        flag_image   = '0;
        live_span    = FLAG_COUNT;
        error_count  = 0;
        idle_enabled = 1'b1;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_bitmap();
        test_extremes();
        test_size_edges();
        test_random_full();
        test_random_sizes();
        test_back_to_back();
        test_drain_pause();

        // Let the last results land, then give a short quiet tail.
        wait_for_results(END_SETTLE);

        if (error_count == 0)
            $display("bitmap_find_set_engine test passed");
        else
            $display("bitmap_find_set_engine test failed");
        $finish;
    end

    // Watchdog: stop a hung run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("%0t: run timed out", $time);
        $display("bitmap_find_set_engine test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bmfs_pkg.sv
rtl/bmfs_ctrl.sv
rtl/bmfs_dp.sv
rtl/bitmap_find_set_engine.sv
bench/tb_top.sv
